/* rtl/core/wfb_pkg.sv */
// Shared types, constants and the CRC byte update for the wavetable frame builder.
package wfb_pkg;

  // Frame geometry.
  localparam int unsigned POS_W = 10;
  localparam logic [POS_W:0] FRAME_SAMPLES = 11'd1024;

  // Frame header and CRC-16/CCITT-FALSE constants.
  localparam logic [7:0]  HDR0      = 8'hDE;
  localparam logic [7:0]  HDR1      = 8'hAD;
  localparam logic [15:0] CRC_START = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'h1021;

  // Byte slots of one request, in transmit order.
  typedef enum logic [2:0] {
    SLOT_HDR0   = 3'd0,
    SLOT_HDR1   = 3'd1,
    SLOT_FN_LO  = 3'd2,
    SLOT_FN_HI  = 3'd3,
    SLOT_SMP_LO = 3'd4,
    SLOT_SMP_HI = 3'd5,
    SLOT_CRC_LO = 3'd6,
    SLOT_CRC_HI = 3'd7
  } slot_e;

  // Everything the byte emitter needs to send the bytes of one sample.
  typedef struct packed {
    logic [15:0] sample;
    logic [15:0] frame_num;
    logic [15:0] crc;
    logic        hdr;
    logic        last;
  } item_t;

  // Status reported by the byte emitter.
  typedef struct packed {
    logic item_busy;
  } emit_status_t;

  // One byte through the MSB-first CRC-16 shift register.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {data, 8'h00};
    for (int b = 0; b < 8; b++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* rtl/core/wfb_if.sv */
// Valid/ready channel interfaces for samples in and frame bytes out.
interface wfb_sample_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface wfb_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       frame_end;

  modport source (output valid, output out_byte, output run_last, output frame_end, input ready);
  modport sink   (input valid, input out_byte, input run_last, input frame_end, output ready);
endinterface

/* rtl/core/wfb_emit.sv */
// Byte emitter: holds one request and sends its frame bytes through an output register.
module wfb_emit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  item_valid_i,
  input  wfb_pkg::item_t        item_i,
  output logic                  item_ready_o,
  output wfb_pkg::emit_status_t status_o,
  wfb_byte_if.source            frm_o
);

  logic                held_q;
  wfb_pkg::item_t      item_q;
  wfb_pkg::slot_e      idx_q;
  wfb_pkg::slot_e      end_idx;
  logic                out_valid_q;
  logic [7:0]          out_byte_q;
  logic                run_last_q;
  logic                frame_end_q;
  logic [7:0]          byte_sel;
  logic                out_free;
  logic                move;
  logic                at_end;
  logic                take;

  // The last slot depends on whether this sample closes the frame.
  assign end_idx  = item_q.last ? wfb_pkg::SLOT_CRC_HI : wfb_pkg::SLOT_SMP_HI;
  assign out_free = !out_valid_q || frm_o.ready;
  assign move     = held_q && out_free;
  assign at_end   = (idx_q == end_idx);

  // A new request may enter while the final byte of the held one moves out.
  assign item_ready_o = !held_q || (move && at_end);
  assign take         = item_valid_i && item_ready_o;

  assign status_o.item_busy = held_q;

  // Byte for the current slot.
  always_comb begin
    unique case (idx_q)
      wfb_pkg::SLOT_HDR0:   byte_sel = wfb_pkg::HDR0;
      wfb_pkg::SLOT_HDR1:   byte_sel = wfb_pkg::HDR1;
      wfb_pkg::SLOT_FN_LO:  byte_sel = item_q.frame_num[7:0];
      wfb_pkg::SLOT_FN_HI:  byte_sel = item_q.frame_num[15:8];
      wfb_pkg::SLOT_SMP_LO: byte_sel = item_q.sample[7:0];
      wfb_pkg::SLOT_SMP_HI: byte_sel = item_q.sample[15:8];
      wfb_pkg::SLOT_CRC_LO: byte_sel = item_q.crc[7:0];
      wfb_pkg::SLOT_CRC_HI: byte_sel = item_q.crc[15:8];
      default:              byte_sel = 8'h00;
    endcase
  end

  // Request holding register and slot counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= 1'b0;
      idx_q  <= wfb_pkg::SLOT_HDR0;
    end else if (take) begin
      held_q <= 1'b1;
      idx_q  <= item_i.hdr ? wfb_pkg::SLOT_HDR0 : wfb_pkg::SLOT_SMP_LO;
    end else if (move && at_end) begin
      held_q <= 1'b0;
    end else if (move) begin
      idx_q  <= wfb_pkg::slot_e'(idx_q + 3'd1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_i;
    end
  end

  // Output register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (move) begin
      out_valid_q <= 1'b1;
    end else if (frm_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (move) begin
      out_byte_q  <= byte_sel;
      run_last_q  <= at_end;
      frame_end_q <= (idx_q == wfb_pkg::SLOT_CRC_HI);
    end
  end

  assign frm_o.valid     = out_valid_q;
  assign frm_o.out_byte  = out_byte_q;
  assign frm_o.run_last  = run_last_q;
  assign frm_o.frame_end = frame_end_q;

endmodule

/* rtl/core/wavetable_frame_builder_crc16_core.sv */
// Top level of the wavetable frame builder with CRC-16/CCITT-FALSE.
//
// Each accepted sample becomes its bytes of a frame: a header (DE, AD, frame
// number low, high) before the first sample, the sample low byte first, and the
// CRC low byte first after the last sample of a frame of 1024 samples. The
// output is one byte per cycle from a registered stage while samples keep coming
// and the receiver is ready, and a new sample is taken in the same cycle as the
// final byte of the previous one leaves the holding register. The first byte of
// a request passes through the holding register and then the output register;
// run_last marks the last byte of each request and frame_end the final CRC byte
// of each frame.
module wavetable_frame_builder_crc16_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  wfb_sample_if.sink  smp_i,
  wfb_byte_if.source  frm_o
);

  logic [wfb_pkg::POS_W-1:0] pos_q;
  logic [15:0]               frame_num_q;
  logic [15:0]               crc_q;
  logic                      accept;
  logic                      item_ready;
  logic                      is_hdr;
  logic                      is_last;
  logic [wfb_pkg::POS_W:0]   pos_inc;
  logic [15:0]               crc_base;
  logic [15:0]               crc_mid;
  logic [15:0]               crc_new;
  wfb_pkg::item_t            item;
  wfb_pkg::emit_status_t     emit_status;

  assign smp_i.ready = item_ready;
  assign accept      = smp_i.valid && item_ready;

  // Frame position decode and CRC over the two sample bytes.
  assign is_hdr   = (pos_q == '0);
  assign pos_inc  = {1'b0, pos_q} + 11'd1;
  assign is_last  = (pos_inc >= wfb_pkg::FRAME_SAMPLES);
  assign crc_base = is_hdr ? wfb_pkg::CRC_START : crc_q;
  assign crc_mid  = wfb_pkg::crc_feed(crc_base, smp_i.sample[7:0]);
  assign crc_new  = wfb_pkg::crc_feed(crc_mid, smp_i.sample[15:8]);

  assign item.sample    = smp_i.sample;
  assign item.frame_num = frame_num_q;
  assign item.crc       = crc_new;
  assign item.hdr       = is_hdr;
  assign item.last      = is_last;

  // Frame state advances on every accepted sample.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      frame_num_q <= '0;
      crc_q       <= wfb_pkg::CRC_START;
    end else if (accept) begin
      if (is_last) begin
        pos_q       <= '0;
        frame_num_q <= frame_num_q + 16'd1;
        crc_q       <= wfb_pkg::CRC_START;
      end else begin
        pos_q <= pos_inc[wfb_pkg::POS_W-1:0];
        crc_q <= crc_new;
      end
    end
  end

  wfb_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (smp_i.valid),
    .item_i       (item),
    .item_ready_o (item_ready),
    .status_o     (emit_status),
    .frm_o        (frm_o)
  );

  // The last byte of a frame is always the last byte of its request.
  a_frame_end_is_run_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frm_o.valid && frm_o.frame_end |-> frm_o.run_last)
    else $error("frame_end without run_last");

  // An accepted request is held by the emitter in the next cycle.
  a_accept_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> emit_status.item_busy)
    else $error("accepted request not held");

  // Closing a frame restarts position and CRC.
  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && is_last |=> (pos_q == '0) && (crc_q == wfb_pkg::CRC_START))
    else $error("frame state not restarted");

endmodule

/* sim/tb_wavetable_frame_builder_crc16_core.sv */
// Self-checking testbench for the wavetable frame builder with CRC-16/CCITT-FALSE.
module tb_wavetable_frame_builder_crc16_core;

  // Run shape: a directed opening followed by random samples, all within the
  // first frame, so the header and the running CRC are exercised.
  localparam int unsigned RANDOM_SAMPLES  = 440;
  localparam int unsigned WIND_DOWN_ITEMS = 100;
  localparam int unsigned SETTLE_CYCLES   = 16;
  localparam int unsigned CYCLE_LIMIT     = 200_000;
  localparam int unsigned MAX_REPORTS     = 10;

  // One frame byte as it should leave the block.
  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       frame_end;
  } frame_byte_t;

  logic clk_i;
  logic rst_ni;

  wfb_sample_if smp ();
  wfb_byte_if   frm ();

  wavetable_frame_builder_crc16_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .smp_i  (smp),
    .frm_o  (frm)
  );

  // Samples waiting to be offered and frame bytes still owed by the block.
  logic [15:0]  samples_pending[$];
  frame_byte_t  frame_bytes_due[$];

  // Predicted frame state.
  logic [15:0]               frame_seq;
  logic [wfb_pkg::POS_W-1:0] frame_pos;
  logic [15:0]               frame_crc;

  int unsigned mismatches;
  int unsigned cycle_count;
  int unsigned send_gap;
  int unsigned take_stall;
  int unsigned samples_sent;
  int unsigned bytes_seen;
  logic        send_idle_phase;
  logic        take_idle_phase;

  // Bitwise CRC-16/CCITT-FALSE update, one data bit at a time, MSB first.
  function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ data[i];
      c  = {c[14:0], 1'b0} ^ (fb ? wfb_pkg::CRC_POLY : 16'h0000);
    end
    return c;
  endfunction

  task automatic owe_byte(input logic [7:0] data, input logic run_last, input logic frame_end);
    frame_byte_t fb;
    fb.data      = data;
    fb.run_last  = run_last;
    fb.frame_end = frame_end;
    frame_bytes_due.push_back(fb);
  endtask

  // Work out the bytes one accepted sample request produces and advance the frame state.
  task automatic build_frame_bytes(input logic [15:0] smp_val);
    logic closes;
    closes = ({1'b0, frame_pos} + 11'd1) >= wfb_pkg::FRAME_SAMPLES;
    if (frame_pos == '0) begin
      frame_crc = wfb_pkg::CRC_START;
      owe_byte(wfb_pkg::HDR0, 1'b0, 1'b0);
      owe_byte(wfb_pkg::HDR1, 1'b0, 1'b0);
      owe_byte(frame_seq[7:0], 1'b0, 1'b0);
      owe_byte(frame_seq[15:8], 1'b0, 1'b0);
    end
    owe_byte(smp_val[7:0], 1'b0, 1'b0);
    owe_byte(smp_val[15:8], !closes, 1'b0);
    frame_crc = crc16_update(frame_crc, smp_val[7:0]);
    frame_crc = crc16_update(frame_crc, smp_val[15:8]);
    if (closes) begin
      owe_byte(frame_crc[7:0], 1'b0, 1'b0);
      owe_byte(frame_crc[15:8], 1'b1, 1'b1);
      frame_seq = frame_seq + 16'd1;
      frame_pos = '0;
      frame_crc = wfb_pkg::CRC_START;
    end else begin
      frame_pos = frame_pos + 1'b1;
    end
  endtask

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Known levels on the channel inputs from the very start.
  initial begin
    smp.valid  = 1'b0;
    smp.sample = '0;
    frm.ready  = 1'b0;
  end

  // Request driver: offers pending samples with random idle bursts between requests.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp.valid       <= 1'b0;
      smp.sample      <= '0;
      send_gap        = 0;
      samples_sent    = 0;
      send_idle_phase = 1'b1;
      frame_seq       = '0;
      frame_pos       = '0;
      frame_crc       = wfb_pkg::CRC_START;
    end else begin
      if (smp.valid && smp.ready) begin
        build_frame_bytes(smp.sample);
        samples_sent++;
        if (samples_sent % 64 == 0) begin
          send_idle_phase = ($urandom_range(0, 3) != 0);
        end
      end
      if (!smp.valid || smp.ready) begin
        if (send_gap == 0 && send_idle_phase && samples_pending.size() > WIND_DOWN_ITEMS &&
            $urandom_range(0, 3) == 0) begin
          send_gap = $urandom_range(1, 14);
        end
        if (send_gap > 0) begin
          send_gap--;
          smp.valid <= 1'b0;
        end else if (samples_pending.size() > 0) begin
          smp.valid  <= 1'b1;
          smp.sample <= samples_pending.pop_front();
        end else begin
          smp.valid <= 1'b0;
        end
      end
    end
  end

  // Byte monitor: checks each accepted byte against the oldest owed byte and
  // stalls the output channel in random bursts.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frm.ready       <= 1'b0;
      take_stall      = 0;
      bytes_seen      = 0;
      take_idle_phase = 1'b1;
    end else begin
      if (frm.valid && frm.ready) begin
        bytes_seen++;
        if (bytes_seen % 128 == 0) begin
          take_idle_phase = ($urandom_range(0, 3) != 0);
        end
        if (frame_bytes_due.size() == 0) begin
          if (mismatches < MAX_REPORTS) begin
            $display("unexpected byte: data=%02h run_last=%0b frame_end=%0b",
                     frm.out_byte, frm.run_last, frm.frame_end);
          end
          mismatches++;
        end else if (frm.out_byte  !== frame_bytes_due[0].data ||
                     frm.run_last  !== frame_bytes_due[0].run_last ||
                     frm.frame_end !== frame_bytes_due[0].frame_end) begin
          if (mismatches < MAX_REPORTS) begin
            $display("byte %0d: expected %02h/%0b/%0b, got %02h/%0b/%0b",
                     bytes_seen, frame_bytes_due[0].data, frame_bytes_due[0].run_last,
                     frame_bytes_due[0].frame_end, frm.out_byte, frm.run_last, frm.frame_end);
          end
          mismatches++;
          void'(frame_bytes_due.pop_front());
        end else begin
          void'(frame_bytes_due.pop_front());
        end
      end
      if (take_stall == 0 && take_idle_phase && samples_pending.size() > WIND_DOWN_ITEMS &&
          $urandom_range(0, 3) == 0) begin
        take_stall = $urandom_range(1, 14);
      end
      if (take_stall > 0) begin
        take_stall--;
        frm.ready <= 1'b0;
      end else begin
        frm.ready <= 1'b1;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Stimulus and end of run.
  initial begin
    logic [15:0] val;
    mismatches  = 0;
    cycle_count = 0;
    rst_ni      = 1'b0;

    // Directed part: zero, all ones, both signed extremes and byte patterns;
    // the very first sample also opens frame zero with its header.
    samples_pending.push_back(16'h0000);
    samples_pending.push_back(16'hFFFF);
    samples_pending.push_back(16'h7FFF);
    samples_pending.push_back(16'h8000);
    samples_pending.push_back(16'h00FF);
    samples_pending.push_back(16'hFF00);
    samples_pending.push_back(16'h5555);
    samples_pending.push_back(16'hAAAA);
    samples_pending.push_back(16'h0001);
    samples_pending.push_back(16'hFFFE);

    // Random part, with signed extremes mixed in now and then.
    for (int i = 0; i < RANDOM_SAMPLES; i++) begin
      case ($urandom_range(0, 15))
        0:       val = 16'h8000;
        1:       val = 16'h7FFF;
        2:       val = 16'hFFFF;
        3:       val = 16'h0000;
        default: val = 16'($urandom);
      endcase
      samples_pending.push_back(val);
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Wait for the last request to be taken and every owed byte to arrive.
    while (samples_pending.size() != 0 || smp.valid) @(posedge clk_i);
    while (frame_bytes_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && frame_bytes_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
